// ===== src/hav_pkg.sv =====
package hav_pkg;

  localparam int QBITS = 30;
  localparam logic signed [33:0] K_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [32:0] PI_Q30 = 33'd3373259426;

  function automatic logic signed [33:0] atan_val(input logic [5:0] i);
    logic signed [33:0] v;
    case (i)
      6'd0: v = 34'sd843314856;
      6'd1: v = 34'sd497837829;
      6'd2: v = 34'sd263043836;
      6'd3: v = 34'sd133525158;
      6'd4: v = 34'sd67021686;
      6'd5: v = 34'sd33543515;
      6'd6: v = 34'sd16775850;
      6'd7: v = 34'sd8388437;
      6'd8: v = 34'sd4194282;
      6'd9: v = 34'sd2097149;
      6'd10: v = 34'sd1048575;
      6'd11: v = 34'sd524287;
      6'd12: v = 34'sd262143;
      6'd13: v = 34'sd131071;
      6'd14: v = 34'sd65535;
      6'd15: v = 34'sd32767;
      6'd16: v = 34'sd16383;
      6'd17: v = 34'sd8191;
      6'd18: v = 34'sd4095;
      6'd19: v = 34'sd2047;
      6'd20: v = 34'sd1023;
      6'd21: v = 34'sd511;
      6'd22: v = 34'sd255;
      6'd23: v = 34'sd127;
      6'd24: v = 34'sd63;
      6'd25: v = 34'sd31;
      6'd26: v = 34'sd15;
      6'd27: v = 34'sd7;
      6'd28: v = 34'sd3;
      6'd29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/haversine_distance.sv =====
// Channel | Direction | Word
// in_     | input     | two points, lat/lon in degrees * 2^FRAC_BITS
// out_    | output    | arc_distance, km * 2^FRAC_BITS
// cfg_    | input     | sphere_radius_km
//
// One pair per cycle unless out_ready stalls the pipe; the stages are seven angle stages,
// the rotation cell row, two stages for a, 31 square-root cells, one stage into
// the vectoring cell row, that row, and two stages for the distance.
// The whole pipe advances only when the last stage is empty or being taken,
// so a stall on out_ready freezes every stage. rst_n clears the valid bits
// and sets the radius to 6371.
module haversine_distance #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [23:0]   in_first_latitude,
  input  logic signed [24:0]   in_first_longitude,
  input  logic signed [23:0]   in_second_latitude,
  input  logic signed [24:0]   in_second_longitude,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_arc_distance,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_sphere_radius_km
);

  localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int G = FRAC_BITS + 1;
  localparam int LAT = 7 + NS + 2 + 31 + 1 + NS + 2;
  localparam logic signed [39:0] FULL = 40'sd360 <<< G;
  localparam logic signed [39:0] HALF = 40'sd180 <<< G;
  localparam logic signed [39:0] QUART = 40'sd90 <<< G;
  localparam logic [39:0] LO_MASK = (40'd1 << G) - 40'd1;
  // A bias of 183 turns keeps the whole-degree count positive.
  localparam logic [17:0] OFF360 = 18'd65880;
  localparam logic [17:0] RCP360 = 18'd186414;
  localparam logic [25:0] RCP180 = 26'd47721859;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [15:0] rad_r;

  assign en = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rad_r <= 16'd6371;
    end else begin
      if (cfg_valid) rad_r <= cfg_sphere_radius_km;
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Stage 0: four angles with G fraction bits.
  logic signed [39:0] ang_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      ang_r[0] <= 40'(in_second_latitude) - 40'(in_first_latitude);
      ang_r[1] <= 40'(in_second_longitude) - 40'(in_first_longitude);
      ang_r[2] <= 40'(in_first_latitude) <<< 1;
      ang_r[3] <= 40'(in_second_latitude) <<< 1;
    end
  end

  // Stage 1: whole degrees and fraction; the turn count of the biased whole
  // degrees comes from a reciprocal multiplication.
  logic [17:0] deg_r [4];
  logic [8:0] turn_r [4];
  logic [39:0] lo_r [4];
  always_ff @(posedge clk) begin
    logic [17:0] u;
    logic [35:0] t;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        u = 18'(ang_r[k] >>> G) + OFF360;
        t = 36'(u) * 36'(RCP360);
        deg_r[k] <= u;
        turn_r[k] <= t[34:26];
        lo_r[k] <= ang_r[k] & LO_MASK;
      end
    end
  end

  // Stage 2: reduce to [-90,90] and note the cosine flip.
  logic signed [39:0] red_r [4];
  logic [3:0] flip_r;
  always_ff @(posedge clk) begin
    logic [8:0] dm;
    logic signed [39:0] r;
    logic f;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        dm = 9'(deg_r[k] - 18'(turn_r[k]) * 18'd360);
        r = $signed((40'(dm) << G) | lo_r[k]);
        if (r >= HALF) r = r - FULL;
        f = 1'b0;
        if (r > QUART) begin r = HALF - r; f = 1'b1; end
        else if (r < -QUART) begin r = -HALF - r; f = 1'b1; end
        red_r[k] <= r;
        flip_r[k] <= f;
      end
    end
  end

  // Stage 3: magnitude and sign.
  logic [24:0] mag_r [4];
  logic [3:0] neg_r, flipa_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mag_r[k] <= 25'(red_r[k] < 0 ? -red_r[k] : red_r[k]);
        neg_r[k] <= red_r[k] < 0;
      end
      flipa_r <= flip_r;
    end
  end

  // Stages 4 to 6: magnitude times pi over 180. The magnitude is split into a
  // multiple of 180 and a remainder whose share comes from a constant table.
  logic [31:0] rtab [180];
  generate
    for (genvar j = 0; j < 180; j++) begin : g_rtab
      assign rtab[j] = 32'((64'(j) * 64'(hav_pkg::PI_Q30)) / 64'd180);
    end
  endgenerate

  logic [17:0] qm_r [4];
  logic [24:0] mag1_r [4];
  logic [3:0] neg1_r, flipb_r;
  always_ff @(posedge clk) begin
    logic [50:0] t;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        t = 51'(mag_r[k]) * 51'(RCP180);
        qm_r[k] <= t[50:33];
        mag1_r[k] <= mag_r[k];
      end
      neg1_r <= neg_r;
      flipb_r <= flipa_r;
    end
  end

  logic [7:0] rm_r [4];
  logic [50:0] hp_r [4];
  logic [3:0] neg2_r, flipc_r;
  always_ff @(posedge clk) begin
    logic [24:0] rem;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rem = mag1_r[k] - 25'(qm_r[k]) * 25'd180;
        rm_r[k] <= rem[7:0];
        hp_r[k] <= 51'(qm_r[k]) * 51'(hav_pkg::PI_Q30);
      end
      neg2_r <= neg1_r;
      flipc_r <= flipb_r;
    end
  end

  logic signed [33:0] z0_r [4];
  logic [3:0] flip3_r;
  always_ff @(posedge clk) begin
    logic [50:0] s;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s = (hp_r[k] + 51'(rtab[rm_r[k]])) >> G;
        z0_r[k] <= neg2_r[k] ? -34'(s) : 34'(s);
      end
      flip3_r <= flipc_r;
    end
  end

  // Rotation rows, four lanes.
  logic signed [33:0] rx [4][NS+1];
  logic signed [33:0] ry [4][NS+1];
  logic signed [33:0] rz [4][NS+1];
  logic rf [4][NS+1];
  genvar L, S;
  generate
    for (L = 0; L < 4; L++) begin : g_lane
      assign rx[L][0] = hav_pkg::K_Q30;
      assign ry[L][0] = '0;
      assign rz[L][0] = z0_r[L];
      assign rf[L][0] = flip3_r[L];
      for (S = 0; S < NS; S++) begin : g_rot
        hav_cordic_cell #(.STEP(S), .VECTOR(1'b0), .SB_W(1)) u_cell (
          .clk(clk), .en(en),
          .x_i(rx[L][S]), .y_i(ry[L][S]), .z_i(rz[L][S]), .sb_i(rf[L][S]),
          .x_o(rx[L][S+1]), .y_o(ry[L][S+1]), .z_o(rz[L][S+1]), .sb_o(rf[L][S+1])
        );
      end
    end
  endgenerate

  // Products, then a and its clamp.
  logic signed [33:0] sdl2_r, c12_r, sdo2_r, a_r;
  always_ff @(posedge clk) begin
    logic signed [33:0] c1, c2;
    logic signed [67:0] p0, p1, p2;
    c1 = rf[2][NS] ? -rx[2][NS] : rx[2][NS];
    c2 = rf[3][NS] ? -rx[3][NS] : rx[3][NS];
    p0 = 68'(ry[0][NS]) * 68'(ry[0][NS]);
    p1 = 68'(c1) * 68'(c2);
    p2 = 68'(ry[1][NS]) * 68'(ry[1][NS]);
    if (en) begin
      sdl2_r <= 34'(p0 >>> hav_pkg::QBITS);
      c12_r <= 34'(p1 >>> hav_pkg::QBITS);
      sdo2_r <= 34'(p2 >>> hav_pkg::QBITS);
    end
  end
  always_ff @(posedge clk) begin
    logic signed [67:0] p;
    logic signed [35:0] s;
    p = 68'(c12_r) * 68'(sdo2_r);
    s = 36'(sdl2_r) + 36'(p >>> hav_pkg::QBITS);
    if (en) begin
      if (s < 0) a_r <= '0;
      else if (s > 36'(hav_pkg::ONE_Q30)) a_r <= hav_pkg::ONE_Q30;
      else a_r <= 34'(s);
    end
  end

  // Two square-root rows side by side; lane 0 gives sqrt(a), lane 1 sqrt(1-a).
  logic [61:0] sn [2][32];
  logic [31:0] sr [2][32];
  generate
    for (L = 0; L < 2; L++) begin : g_sq
      assign sn[L][0] = (L == 0) ? (62'(a_r) << hav_pkg::QBITS)
                                 : (62'(hav_pkg::ONE_Q30 - a_r) << hav_pkg::QBITS);
      assign sr[L][0] = '0;
      for (S = 0; S < 31; S++) begin : g_cell
        hav_sqrt_cell #(.STEP(S), .SB_W(1)) u_cell (
          .clk(clk), .en(en), .n_i(sn[L][S]), .res_i(sr[L][S]), .sb_i(1'b0),
          .n_o(sn[L][S+1]), .res_o(sr[L][S+1]), .sb_o()
        );
      end
    end
  endgenerate

  logic signed [33:0] vx0_r, vy0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      vy0_r <= 34'(sr[0][31]);
      vx0_r <= 34'(sr[1][31]);
    end
  end

  logic signed [33:0] vx [NS+1];
  logic signed [33:0] vy [NS+1];
  logic signed [33:0] vz [NS+1];
  assign vx[0] = vx0_r;
  assign vy[0] = vy0_r;
  assign vz[0] = '0;
  generate
    for (S = 0; S < NS; S++) begin : g_vec
      hav_cordic_cell #(.STEP(S), .VECTOR(1'b1), .SB_W(1)) u_cell (
        .clk(clk), .en(en), .x_i(vx[S]), .y_i(vy[S]), .z_i(vz[S]), .sb_i(1'b0),
        .x_o(vx[S+1]), .y_o(vy[S+1]), .z_o(vz[S+1]), .sb_o()
      );
    end
  endgenerate

  logic [50:0] dprod_r;
  logic [31:0] dist_r;
  always_ff @(posedge clk) begin
    logic [33:0] zc;
    logic [50:0] d;
    zc = vz[NS] < 0 ? '0 : vz[NS];
    d = dprod_r >> (hav_pkg::QBITS - FRAC_BITS);
    if (en) begin
      dprod_r <= 51'({rad_r, 1'b0}) * 51'(zc);
      dist_r <= (d > 51'hFFFFFFFF) ? 32'hFFFFFFFF : d[31:0];
    end
  end
  assign out_arc_distance = dist_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_arc_distance))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !vld_r[LAT-2] |=> !out_valid)
    else $error("result repeated");

endmodule

// ===== src/hav_cordic_cell.sv =====
// One CORDIC micro-rotation, registered. Used for rotation (steer by z) and
// vectoring (steer by y). Sideband data rides along unchanged.
module hav_cordic_cell #(
  parameter int STEP = 0,
  parameter bit VECTOR = 1'b0,
  parameter int SB_W = 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [33:0]      x_i,
  input  logic signed [33:0]      y_i,
  input  logic signed [33:0]      z_i,
  input  logic [SB_W-1:0]         sb_i,
  output logic signed [33:0]      x_o,
  output logic signed [33:0]      y_o,
  output logic signed [33:0]      z_o,
  output logic [SB_W-1:0]         sb_o
);

  logic signed [33:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [SB_W-1:0] sb_r;
  logic pos;
  logic signed [33:0] xs, ys, at;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    at = hav_pkg::atan_val(6'(STEP));
    pos = VECTOR ? (y_i >= 0) : (z_i >= 0);
    if (VECTOR) begin
      x_nxt = pos ? x_i + ys : x_i - ys;
      y_nxt = pos ? y_i - xs : y_i + xs;
      z_nxt = pos ? z_i + at : z_i - at;
    end else begin
      x_nxt = pos ? x_i - ys : x_i + ys;
      y_nxt = pos ? y_i + xs : y_i - xs;
      z_nxt = pos ? z_i - at : z_i + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      sb_r <= sb_i;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign sb_o = sb_r;

endmodule

// ===== src/hav_sqrt_cell.sv =====
// One step of a restoring integer square root (two radicand bits per cell).
module hav_sqrt_cell #(
  parameter int STEP = 0,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [61:0]     n_i,
  input  logic [31:0]     res_i,
  input  logic [SB_W-1:0] sb_i,
  output logic [61:0]     n_o,
  output logic [31:0]     res_o,
  output logic [SB_W-1:0] sb_o
);

  localparam int SH = 60 - 2 * STEP;

  logic [61:0] n_r, n_nxt;
  logic [31:0] res_r, res_nxt;
  logic [SB_W-1:0] sb_r;
  logic [63:0] trial;

  always_comb begin
    trial = ({32'd0, res_i} << (SH / 2 + 1)) + (64'd1 << SH);
    if ({2'b00, n_i} >= trial) begin
      n_nxt = n_i - trial[61:0];
      res_nxt = res_i | (32'd1 << (SH / 2));
    end else begin
      n_nxt = n_i;
      res_nxt = res_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_nxt;
      res_r <= res_nxt;
      sb_r <= sb_i;
    end
  end

  assign n_o = n_r;
  assign res_o = res_r;
  assign sb_o = sb_r;

endmodule

// ===== test/tb_haversine_distance.sv =====
`timescale 1ns / 1ps

module tb_haversine_distance;

  typedef struct {
    logic signed [23:0] lat1;
    logic signed [24:0] lon1;
    logic signed [23:0] lat2;
    logic signed [24:0] lon2;
  } point_pair_t;

  localparam longint LAT_MAX = 5898240;
  localparam longint LON_MAX = 11796480;
  localparam int LATENCY = 43 + 2 * 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [23:0] in_first_latitude;
  logic signed [24:0] in_first_longitude;
  logic signed [23:0] in_second_latitude;
  logic signed [24:0] in_second_longitude;
  logic out_valid;
  logic out_ready;
  logic [31:0] out_arc_distance;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_sphere_radius_km;

  point_pair_t pair_q[$];
  logic [31:0] distance_q[$];
  longint radius_km;
  int send_idle;
  int recv_stall;
  int mismatches = 0;
  bit hold_go;
  bit hold_used;
  int hold_left;

  haversine_distance DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_first_latitude(in_first_latitude),
    .in_first_longitude(in_first_longitude),
    .in_second_latitude(in_second_latitude),
    .in_second_longitude(in_second_longitude),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_arc_distance(out_arc_distance),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_sphere_radius_km(cfg_sphere_radius_km)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Angle carries 17 fractional bits of degrees; results are Q30.
  function automatic void rotate_angle(input longint ang, output longint cosv,
                                       output longint sinv);
    longint full_turn, half_turn, quarter, r, mag, z, x, y, t;
    bit flip;
    full_turn = longint'(360) <<< 17;
    half_turn = longint'(180) <<< 17;
    quarter = longint'(90) <<< 17;
    flip = 0;
    r = ang % full_turn;
    if (r < 0) r += full_turn;
    if (r >= half_turn) r -= full_turn;
    if (r > quarter) begin
      r = half_turn - r;
      flip = 1;
    end else if (r < -quarter) begin
      r = -half_turn - r;
      flip = 1;
    end
    mag = (r < 0) ? -r : r;
    z = longint'((longint'(unsigned'(mag)) * longint'(hav_pkg::PI_Q30)) / 180) >>> 17;
    if (r < 0) z = -z;
    x = longint'(hav_pkg::K_Q30);
    y = 0;
    for (int i = 0; i < 20; i++) begin
      t = x;
      if (z >= 0) begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z -= longint'(hav_pkg::atan_val(6'(i)));
      end else begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z += longint'(hav_pkg::atan_val(6'(i)));
      end
    end
    cosv = flip ? -x : x;
    sinv = y;
  endfunction

  function automatic longint floor_root(input longint n);
    longint res, bitv;
    res = 0;
    bitv = longint'(1) <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] arc_of(input point_pair_t p, input longint radius);
    longint la1, lo1, la2, lo2, c1, c2, cdl, sdl, cdo, sdo, a, x, y, z, t, d;
    la1 = p.lat1;
    lo1 = p.lon1;
    la2 = p.lat2;
    lo2 = p.lon2;
    rotate_angle(la2 - la1, cdl, sdl);
    rotate_angle(lo2 - lo1, cdo, sdo);
    rotate_angle(la1 * 2, c1, t);
    rotate_angle(la2 * 2, c2, t);
    a = ((sdl * sdl) >>> 30) + ((((c1 * c2) >>> 30) * ((sdo * sdo) >>> 30)) >>> 30);
    if (a < 0) a = 0;
    if (a > longint'(hav_pkg::ONE_Q30)) a = longint'(hav_pkg::ONE_Q30);
    y = floor_root(a <<< 30);
    x = floor_root((longint'(hav_pkg::ONE_Q30) - a) <<< 30);
    z = 0;
    for (int i = 0; i < 20; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z += longint'(hav_pkg::atan_val(6'(i)));
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z -= longint'(hav_pkg::atan_val(6'(i)));
      end
    end
    if (z < 0) z = 0;
    d = (2 * radius * z) >>> 14;
    if (d > 64'hFFFFFFFF) d = 64'hFFFFFFFF;
    return d[31:0];
  endfunction

  function automatic longint pick(input longint lim);
    return longint'($urandom_range(32'(2 * lim))) - lim;
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t p;
    int sel;
    sel = int'($urandom_range(99));
    if (sel < 15) begin
      // Raw bit patterns, wrapping past the nominal angle range.
      p.lat1 = 24'($urandom);
      p.lon1 = 25'($urandom);
      p.lat2 = 24'($urandom);
      p.lon2 = 25'($urandom);
    end else if (sel < 30) begin
      // Nearby points, where a is tiny.
      p.lat1 = 24'(pick(LAT_MAX - 4096));
      p.lon1 = 25'(pick(LON_MAX - 4096));
      p.lat2 = 24'(longint'(p.lat1) + pick(longint'(4096 >> $urandom_range(12))));
      p.lon2 = 25'(longint'(p.lon1) + pick(longint'(4096 >> $urandom_range(12))));
    end else begin
      p.lat1 = 24'(pick(LAT_MAX));
      p.lon1 = 25'(pick(LON_MAX));
      p.lat2 = 24'(pick(LAT_MAX));
      p.lon2 = 25'(pick(LON_MAX));
    end
    return p;
  endfunction

  function automatic point_pair_t make_pair(input longint la1, input longint lo1,
                                            input longint la2, input longint lo2);
    point_pair_t p;
    p.lat1 = 24'(la1);
    p.lon1 = 25'(lo1);
    p.lat2 = 24'(la2);
    p.lon2 = 25'(lo2);
    return p;
  endfunction

  // Input driver: a new word is offered once the current one is taken.
  always @(posedge clk) begin
    point_pair_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_first_latitude <= '0;
      in_first_longitude <= '0;
      in_second_latitude <= '0;
      in_second_longitude <= '0;
    end else begin
      if (in_valid && in_ready) begin
        p.lat1 = in_first_latitude;
        p.lon1 = in_first_longitude;
        p.lat2 = in_second_latitude;
        p.lon2 = in_second_longitude;
        distance_q.push_back(arc_of(p, radius_km));
      end
      if (!in_valid || in_ready) begin
        if (pair_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          p = pair_q.pop_front();
          in_first_latitude <= p.lat1;
          in_first_longitude <= p.lon1;
          in_second_latitude <= p.lat2;
          in_second_longitude <= p.lon2;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      hold_left <= 300;
      hold_used <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (distance_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: arc_distance %0d", out_arc_distance);
        end else begin
          want = distance_q.pop_front();
          if (out_arc_distance !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("arc_distance mismatch: expected %0d, got %0d", want,
                       out_arc_distance);
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic wait_drained();
    while (pair_q.size() > 0 || distance_q.size() > 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_radius(input logic [15:0] value);
    @(posedge clk);
    cfg_sphere_radius_km <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    radius_km = longint'(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] radius, input int idle, input int stall,
                           input int count);
    wait_drained();
    write_radius(radius);
    send_idle = idle;
    recv_stall = stall;
    repeat (count) pair_q.push_back(random_pair());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_sphere_radius_km = 16'd0;
    radius_km = 6371;
    send_idle = 0;
    recv_stall = 0;
    hold_go = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset radius.
    pair_q.push_back(make_pair(0, 0, 0, 0));
    pair_q.push_back(make_pair(0, 0, 0, LON_MAX));
    pair_q.push_back(make_pair(0, -LON_MAX, 0, LON_MAX));
    pair_q.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
    pair_q.push_back(make_pair(LAT_MAX, 123456, LAT_MAX, -LON_MAX));
    pair_q.push_back(make_pair(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX));
    pair_q.push_back(make_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX));
    pair_q.push_back(make_pair(0, 0, 1, 1));
    pair_q.push_back(make_pair(100, 200, 100, 200));
    pair_q.push_back(make_pair(-8388608, -16777216, 8388607, 16777215));
    pair_q.push_back(make_pair(8388607, 16777215, -8388608, -16777216));
    pair_q.push_back(make_pair(-1, -1, -1, -1));
    pair_q.push_back(make_pair(3276800, 5898240, -3276800, -5898240));
    pair_q.push_back(make_pair(2949120, 0, -2949120, LON_MAX));
    pair_q.push_back(make_pair(0, 5898240, 0, -5898240));
    pair_q.push_back(make_pair(LAT_MAX - 1, 0, LAT_MAX, 1));

    run_phase(16'd6371, 0, 0, 200);
    run_phase(16'd65535, 68, 0, 200);
    run_phase(16'd1, 0, 68, 150);
    hold_go = 1;
    run_phase(16'd0, 20, 20, 100);
    run_phase(16'($urandom_range(65535)), 20, 20, 150);
    run_phase(16'd6371, 0, 0, 100);
    wait_drained();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
